>>> sv/transport_block_size_calc_core_macros.svh
// ----------------------------------------------------------------------------
// transport_block_size_calc_core_macros: assertion helpers
// Concurrent assertion wrappers shared by the transport block size core.
// They compile to nothing in a synthesis build.
// ----------------------------------------------------------------------------
`ifndef TRANSPORT_BLOCK_SIZE_CALC_CORE_MACROS_SVH
`define TRANSPORT_BLOCK_SIZE_CALC_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define TBS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tbs assertion failed");
// condition must never be seen outside reset
`define TBS_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("tbs forbidden condition seen");
`else
`define TBS_ASSERT(lbl, clk, rst, prop)
`define TBS_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

>>> sv/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg: shared types and constants
// Field widths, queue sizing, divider pipeline shapes and the beat type that
// travels from the front part through the queue to the back part.
// ----------------------------------------------------------------------------
package tbs_pkg;

   // field widths
   localparam int unsigned SS_W     = 4;
   localparam int unsigned SC_W     = 14;
   localparam int unsigned BPS_W    = 4;
   localparam int unsigned RATE_W   = 4;
   localparam int unsigned Z_W      = 14;
   localparam int unsigned BITS_W   = 25;
   localparam int unsigned STATUS_W = 2;

   // partial products: streams * bits per symbol, subcarriers * numerator
   localparam int unsigned PPA_W  = SS_W + BPS_W;
   localparam int unsigned PPB_W  = SC_W + RATE_W;
   localparam int unsigned PROD_W = PPA_W + PPB_W;

   // queue between front and back
   localparam int unsigned QDEPTH  = 4;
   localparam int unsigned QPTR_W  = $clog2(QDEPTH);
   localparam int unsigned QCNT_W  = QPTR_W + 1;
   localparam int unsigned QFILL_W = QCNT_W + 1;
   localparam logic [QCNT_W-1:0]  QFULL      = QCNT_W'(QDEPTH);
   localparam logic [QFILL_W-1:0] QFILL_LIMIT = QFILL_W'(QDEPTH);

   // code rate divider: quotient bits per stage and stage count
   localparam int unsigned D1_STEP   = 4;
   localparam int unsigned D1_STAGES = (PROD_W + D1_STEP - 1) / D1_STEP;
   localparam int unsigned D1_W      = D1_STEP * D1_STAGES;
   localparam int unsigned D1_REM_W  = RATE_W;

   // segmentation divider
   localparam int unsigned D2_STEP   = 2;
   localparam int unsigned D2_STAGES = (BITS_W + D2_STEP - 1) / D2_STEP;
   localparam int unsigned D2_W      = D2_STEP * D2_STAGES;
   localparam int unsigned D2_REM_W  = Z_W;

   // crc overhead width: (blocks + 1) * 24
   localparam int unsigned BLK_W = D2_W + 1;
   localparam int unsigned OVH_W = BLK_W + 5;

   localparam logic [BITS_W-1:0] CRC_BITS  = BITS_W'(24);
   localparam logic [BITS_W-1:0] CODED_MAX = '1;
   localparam logic [Z_W-1:0]    Z_MIN     = Z_W'(25);
   localparam logic [Z_W-1:0]    Z_RESET   = Z_W'(2048);

   // quantization thresholds
   localparam logic [BITS_W-1:0] LIMIT_M8  = BITS_W'(512);
   localparam logic [BITS_W-1:0] LIMIT_M16 = BITS_W'(1024);
   localparam logic [BITS_W-1:0] LIMIT_M32 = BITS_W'(2048);

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_TOO_SMALL    = 2'd1,
      ST_NOT_POSITIVE = 2'd2,
      ST_ZERO_DEN     = 2'd3
   } status_type;

   // one classified request
   typedef struct packed {
      logic [PROD_W-1:0] product;
      logic [RATE_W-1:0] den;
      logic              den_zero;
   } item_type;

   // one beat between front, queue and back
   typedef struct packed {
      logic     valid;
      item_type item;
   } beat_type;

endpackage

>>> sv/tbs_front.sv
// ----------------------------------------------------------------------------
// tbs_front: request intake
// Takes request beats, flags a zero denominator and forms the rate product
// streams * subcarriers * bits per symbol * numerator over two stages.
// Busy is raised when the queue could not hold every beat in flight.
// ----------------------------------------------------------------------------
`include "transport_block_size_calc_core_macros.svh"

module tbs_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [tbs_pkg::SS_W-1:0]     spatial_streams,
   input  logic [tbs_pkg::SC_W-1:0]     data_subcarriers,
   input  logic [tbs_pkg::BPS_W-1:0]    bits_per_symbol,
   input  logic [tbs_pkg::RATE_W-1:0]   rate_numerator,
   input  logic [tbs_pkg::RATE_W-1:0]   rate_denominator,
   input  logic [tbs_pkg::QCNT_W-1:0]   queue_level,
   output tbs_pkg::beat_type            push
);

   logic                         accept;
   logic [tbs_pkg::QFILL_W-1:0]  fill;

   logic                         v1_ff;
   logic [tbs_pkg::SS_W-1:0]     ss1_ff;
   logic [tbs_pkg::SC_W-1:0]     sc1_ff;
   logic [tbs_pkg::BPS_W-1:0]    bps1_ff;
   logic [tbs_pkg::RATE_W-1:0]   num1_ff;
   logic [tbs_pkg::RATE_W-1:0]   den1_ff;
   logic                         dz1_ff;

   logic                         v2_ff;
   logic [tbs_pkg::PPA_W-1:0]    ppa2_ff;
   logic [tbs_pkg::PPA_W-1:0]    ppa2_in;
   logic [tbs_pkg::PPB_W-1:0]    ppb2_ff;
   logic [tbs_pkg::PPB_W-1:0]    ppb2_in;
   logic [tbs_pkg::RATE_W-1:0]   den2_ff;
   logic                         dz2_ff;

   // credit check: queue entries against beats already in the front
   always_comb begin
      fill = tbs_pkg::QFILL_W'(queue_level) + tbs_pkg::QFILL_W'(v1_ff)
           + tbs_pkg::QFILL_W'(v2_ff);
      busy = (fill >= tbs_pkg::QFILL_LIMIT);
   end

   assign accept = start & ~busy;

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   // stage 1: capture request beat and classify
   always_ff @(posedge clock) begin
      if (accept) begin
         ss1_ff  <= spatial_streams;
         sc1_ff  <= data_subcarriers;
         bps1_ff <= bits_per_symbol;
         num1_ff <= rate_numerator;
         den1_ff <= rate_denominator;
         dz1_ff  <= (rate_denominator == '0);
      end
   end

   // stage 2: two narrow partial products
   always_comb begin
      ppa2_in = tbs_pkg::PPA_W'(ss1_ff) * tbs_pkg::PPA_W'(bps1_ff);
      ppb2_in = tbs_pkg::PPB_W'(sc1_ff) * tbs_pkg::PPB_W'(num1_ff);
   end

   always_ff @(posedge clock) begin
      ppa2_ff <= ppa2_in;
      ppb2_ff <= ppb2_in;
      den2_ff <= den1_ff;
      dz2_ff  <= dz1_ff;
   end

   // full product goes straight into the queue
   always_comb begin
      push.valid         = v2_ff;
      push.item.product  = tbs_pkg::PROD_W'(ppa2_ff) * tbs_pkg::PROD_W'(ppb2_ff);
      push.item.den      = den2_ff;
      push.item.den_zero = dz2_ff;
   end

   `TBS_ASSERT(a_front_take, clock, reset, (start && !busy) |=> v1_ff)

endmodule

>>> sv/tbs_queue.sv
// ----------------------------------------------------------------------------
// tbs_queue: request queue
// Small register queue between the front and back parts. The head beat is
// offered whenever the queue holds one.
// ----------------------------------------------------------------------------
`include "transport_block_size_calc_core_macros.svh"

module tbs_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  tbs_pkg::beat_type           push,
   output tbs_pkg::beat_type           pop,
   output logic [tbs_pkg::QCNT_W-1:0]  level
);

   tbs_pkg::item_type             mem_ff [tbs_pkg::QDEPTH];
   logic [tbs_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [tbs_pkg::QPTR_W-1:0]    wr_ptr_in;
   logic [tbs_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [tbs_pkg::QPTR_W-1:0]    rd_ptr_in;
   logic [tbs_pkg::QCNT_W-1:0]    count_ff;
   logic [tbs_pkg::QCNT_W-1:0]    count_in;
   logic                          empty;
   logic                          take;

   assign empty = (count_ff == '0);
   assign take  = ~empty;
   assign level = count_ff;

   // head beat
   always_comb begin
      pop.valid = take;
      pop.item  = mem_ff[rd_ptr_ff];
   end

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push.valid, take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   `TBS_ASSERT_NEVER(a_q_overflow, clock, reset, push.valid && (count_ff == tbs_pkg::QFULL))
   `TBS_ASSERT(a_q_through, clock, reset, (empty && push.valid) |=> pop.valid)

endmodule

>>> sv/tbs_back.sv
// ----------------------------------------------------------------------------
// tbs_back: size calculation pipeline
// Pipelined division by the rate denominator, saturation and quantization,
// pipelined division by the code block size for segmentation, then crc
// overhead removal and status. Advances every cycle and never stalls.
// ----------------------------------------------------------------------------
`include "transport_block_size_calc_core_macros.svh"

module tbs_back (
   input  logic                           clock,
   input  logic                           reset,
   input  tbs_pkg::beat_type              head,
   input  logic [tbs_pkg::Z_W-1:0]        max_code_block_bits,
   output logic                           rsp_strobe,
   output logic [tbs_pkg::BITS_W-1:0]     rsp_coded_bits,
   output logic [tbs_pkg::BITS_W-1:0]     rsp_block_bits,
   output logic [tbs_pkg::STATUS_W-1:0]   rsp_status
);

   // round down to a multiple of 8, 16, 32 or 64 by size
   function automatic logic [tbs_pkg::BITS_W-1:0] quantize(
      input logic [tbs_pkg::BITS_W-1:0] coded
   );
      logic [tbs_pkg::BITS_W-1:0] mask;
      if (coded <= tbs_pkg::LIMIT_M8) begin
         mask = ~tbs_pkg::BITS_W'(7);
      end else if (coded <= tbs_pkg::LIMIT_M16) begin
         mask = ~tbs_pkg::BITS_W'(15);
      end else if (coded <= tbs_pkg::LIMIT_M32) begin
         mask = ~tbs_pkg::BITS_W'(31);
      end else begin
         mask = ~tbs_pkg::BITS_W'(63);
      end
      return coded & mask;
   endfunction

   // effective code block size, never below the minimum
   logic [tbs_pkg::Z_W-1:0]        z_eff_ff;
   logic [tbs_pkg::Z_W-1:0]        z_eff_in;

   // rate divider taps: tap 0 is the head beat, tap n after n stages
   logic [tbs_pkg::D1_STAGES:0]    d1_v_ff;
   logic [tbs_pkg::D1_REM_W-1:0]   d1_rem_ff [tbs_pkg::D1_STAGES+1];
   logic [tbs_pkg::D1_W-1:0]       d1_dq_ff  [tbs_pkg::D1_STAGES+1];
   logic [tbs_pkg::RATE_W-1:0]     d1_den_ff [tbs_pkg::D1_STAGES+1];
   logic                           d1_dz_ff  [tbs_pkg::D1_STAGES+1];
   logic [tbs_pkg::D1_REM_W-1:0]   d1_rem_in [tbs_pkg::D1_STAGES];
   logic [tbs_pkg::D1_W-1:0]       d1_dq_in  [tbs_pkg::D1_STAGES];

   // quantization
   logic [tbs_pkg::D1_W-1:0]       quot;
   logic [tbs_pkg::BITS_W-1:0]     coded;
   logic [tbs_pkg::BITS_W-1:0]     nm;

   // segmentation divider taps: tap 0 is the quantized beat
   logic [tbs_pkg::D2_STAGES:0]    d2_v_ff;
   logic [tbs_pkg::D2_REM_W-1:0]   d2_rem_ff   [tbs_pkg::D2_STAGES+1];
   logic [tbs_pkg::D2_W-1:0]       d2_dq_ff    [tbs_pkg::D2_STAGES+1];
   logic [tbs_pkg::BITS_W-1:0]     d2_coded_ff [tbs_pkg::D2_STAGES+1];
   logic [tbs_pkg::BITS_W-1:0]     d2_nm_ff    [tbs_pkg::D2_STAGES+1];
   logic                           d2_dz_ff    [tbs_pkg::D2_STAGES+1];
   logic                           d2_small_ff [tbs_pkg::D2_STAGES+1];
   logic                           d2_fits_ff  [tbs_pkg::D2_STAGES+1];
   logic [tbs_pkg::D2_REM_W-1:0]   d2_rem_in   [tbs_pkg::D2_STAGES];
   logic [tbs_pkg::D2_W-1:0]       d2_dq_in    [tbs_pkg::D2_STAGES];

   // overhead stage
   logic [tbs_pkg::BLK_W-1:0]      blocks;
   logic [tbs_pkg::OVH_W-1:0]      ovh_in;
   logic                           c1_v_ff;
   logic [tbs_pkg::BITS_W-1:0]     c1_coded_ff;
   logic [tbs_pkg::BITS_W-1:0]     c1_nm_ff;
   logic                           c1_dz_ff;
   logic                           c1_small_ff;
   logic                           c1_fits_ff;
   logic [tbs_pkg::OVH_W-1:0]      c1_ovh_ff;

   // result stage
   logic                           strobe_ff;
   logic [tbs_pkg::BITS_W-1:0]     coded_ff;
   logic [tbs_pkg::BITS_W-1:0]     coded_in;
   logic [tbs_pkg::BITS_W-1:0]     block_ff;
   logic [tbs_pkg::BITS_W-1:0]     block_in;
   tbs_pkg::status_type            status_ff;
   tbs_pkg::status_type            status_in;

   assign z_eff_in = (max_code_block_bits < tbs_pkg::Z_MIN) ? tbs_pkg::Z_MIN
                                                            : max_code_block_bits;

   always_ff @(posedge clock) begin
      z_eff_ff <= z_eff_in;
   end

   // valid shift lines
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff   <= '0;
         d2_v_ff   <= '0;
         c1_v_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         d1_v_ff   <= {d1_v_ff[tbs_pkg::D1_STAGES-1:0], head.valid};
         d2_v_ff   <= {d2_v_ff[tbs_pkg::D2_STAGES-1:0], d1_v_ff[tbs_pkg::D1_STAGES]};
         c1_v_ff   <= d2_v_ff[tbs_pkg::D2_STAGES];
         strobe_ff <= c1_v_ff;
      end
   end

   // rate divider load from queue head
   always_ff @(posedge clock) begin
      d1_rem_ff[0] <= '0;
      d1_dq_ff[0]  <= tbs_pkg::D1_W'(head.item.product);
      d1_den_ff[0] <= head.item.den;
      d1_dz_ff[0]  <= head.item.den_zero;
   end

   // rate divider stages, restoring, several quotient bits each
   for (genvar s = 0; s < tbs_pkg::D1_STAGES; s++) begin : g_d1
      always_comb begin
         logic [tbs_pkg::D1_REM_W:0]   trial;
         logic [tbs_pkg::D1_REM_W-1:0] rem_w;
         logic [tbs_pkg::D1_W-1:0]     dq_w;
         rem_w = d1_rem_ff[s];
         dq_w  = d1_dq_ff[s];
         for (int k = 0; k < tbs_pkg::D1_STEP; k++) begin
            trial = {rem_w, dq_w[tbs_pkg::D1_W-1]};
            dq_w  = {dq_w[tbs_pkg::D1_W-2:0], 1'b0};
            if (trial >= {1'b0, d1_den_ff[s]}) begin
               trial   = trial - {1'b0, d1_den_ff[s]};
               dq_w[0] = 1'b1;
            end
            rem_w = trial[tbs_pkg::D1_REM_W-1:0];
         end
         d1_rem_in[s] = rem_w;
         d1_dq_in[s]  = dq_w;
      end

      always_ff @(posedge clock) begin
         d1_rem_ff[s+1] <= d1_rem_in[s];
         d1_dq_ff[s+1]  <= d1_dq_in[s];
         d1_den_ff[s+1] <= d1_den_ff[s];
         d1_dz_ff[s+1]  <= d1_dz_ff[s];
      end
   end

   // saturate and quantize
   always_comb begin
      quot  = d1_dq_ff[tbs_pkg::D1_STAGES];
      coded = (|quot[tbs_pkg::D1_W-1:tbs_pkg::BITS_W]) ? tbs_pkg::CODED_MAX
                                                       : quot[tbs_pkg::BITS_W-1:0];
      nm    = quantize(coded);
   end

   // segmentation divider load: payload after the transport crc
   always_ff @(posedge clock) begin
      d2_rem_ff[0]   <= '0;
      d2_dq_ff[0]    <= tbs_pkg::D2_W'(nm - tbs_pkg::CRC_BITS);
      d2_coded_ff[0] <= coded;
      d2_nm_ff[0]    <= nm;
      d2_dz_ff[0]    <= d1_dz_ff[tbs_pkg::D1_STAGES];
      d2_small_ff[0] <= (nm <= tbs_pkg::CRC_BITS);
      d2_fits_ff[0]  <= (nm <= tbs_pkg::BITS_W'(z_eff_ff));
   end

   // segmentation divider stages
   for (genvar s = 0; s < tbs_pkg::D2_STAGES; s++) begin : g_d2
      always_comb begin
         logic [tbs_pkg::D2_REM_W:0]   trial;
         logic [tbs_pkg::D2_REM_W-1:0] rem_w;
         logic [tbs_pkg::D2_W-1:0]     dq_w;
         rem_w = d2_rem_ff[s];
         dq_w  = d2_dq_ff[s];
         for (int k = 0; k < tbs_pkg::D2_STEP; k++) begin
            trial = {rem_w, dq_w[tbs_pkg::D2_W-1]};
            dq_w  = {dq_w[tbs_pkg::D2_W-2:0], 1'b0};
            if (trial >= {1'b0, z_eff_ff}) begin
               trial   = trial - {1'b0, z_eff_ff};
               dq_w[0] = 1'b1;
            end
            rem_w = trial[tbs_pkg::D2_REM_W-1:0];
         end
         d2_rem_in[s] = rem_w;
         d2_dq_in[s]  = dq_w;
      end

      always_ff @(posedge clock) begin
         d2_rem_ff[s+1]   <= d2_rem_in[s];
         d2_dq_ff[s+1]    <= d2_dq_in[s];
         d2_coded_ff[s+1] <= d2_coded_ff[s];
         d2_nm_ff[s+1]    <= d2_nm_ff[s];
         d2_dz_ff[s+1]    <= d2_dz_ff[s];
         d2_small_ff[s+1] <= d2_small_ff[s];
         d2_fits_ff[s+1]  <= d2_fits_ff[s];
      end
   end

   // code blocks rounded up, plus one for the transport crc, times 24
   always_comb begin
      blocks = tbs_pkg::BLK_W'(d2_dq_ff[tbs_pkg::D2_STAGES])
             + tbs_pkg::BLK_W'(d2_rem_ff[tbs_pkg::D2_STAGES] != '0)
             + tbs_pkg::BLK_W'(1);
      ovh_in = (tbs_pkg::OVH_W'(blocks) << 4) + (tbs_pkg::OVH_W'(blocks) << 3);
   end

   always_ff @(posedge clock) begin
      c1_coded_ff <= d2_coded_ff[tbs_pkg::D2_STAGES];
      c1_nm_ff    <= d2_nm_ff[tbs_pkg::D2_STAGES];
      c1_dz_ff    <= d2_dz_ff[tbs_pkg::D2_STAGES];
      c1_small_ff <= d2_small_ff[tbs_pkg::D2_STAGES];
      c1_fits_ff  <= d2_fits_ff[tbs_pkg::D2_STAGES];
      c1_ovh_ff   <= ovh_in;
   end

   // final size and status
   always_comb begin
      coded_in  = c1_coded_ff;
      block_in  = '0;
      status_in = tbs_pkg::ST_OK;
      if (c1_dz_ff) begin
         coded_in  = '0;
         status_in = tbs_pkg::ST_ZERO_DEN;
      end else if (c1_small_ff) begin
         status_in = tbs_pkg::ST_TOO_SMALL;
      end else if (c1_fits_ff) begin
         block_in = c1_nm_ff - tbs_pkg::CRC_BITS;
      end else if (c1_ovh_ff >= tbs_pkg::OVH_W'(c1_nm_ff)) begin
         status_in = tbs_pkg::ST_NOT_POSITIVE;
      end else begin
         block_in = c1_nm_ff - c1_ovh_ff[tbs_pkg::BITS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      coded_ff  <= coded_in;
      block_ff  <= block_in;
      status_ff <= status_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_coded_bits = coded_ff;
   assign rsp_block_bits = block_ff;
   assign rsp_status     = status_ff;

   `TBS_ASSERT(a_back_zden, clock, reset, (strobe_ff && (status_ff == tbs_pkg::ST_ZERO_DEN)) |-> ((coded_ff == '0) && (block_ff == '0)))
   `TBS_ASSERT(a_back_ok_size, clock, reset, strobe_ff |-> ((status_ff == tbs_pkg::ST_OK) == (block_ff != '0)))

endmodule

>>> sv/transport_block_size_calc_core.sv
// ----------------------------------------------------------------------------
// transport_block_size_calc_core: transport block size calculator
// Computes coded data-channel bits and the transport block size after crc
// and code block segmentation overhead, accepting one request per cycle while busy is low.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: drive the req_ fields and raise start; the request beat
//   is taken at a rising edge with start high and busy low.
//   Result channel: rsp_strobe is high for exactly one cycle with the result
//   beat on rsp_coded_bits, rsp_block_bits and rsp_status; results come back
//   in request order.
//   Path: a request beat passes two intake stages, the queue, the divider
//   load register, the seven-stage rate divider, the quantizer, the
//   segmentation load register, the thirteen-stage segmentation divider
//   and two result stages before its result beat is taken.
//   Throughput: one request per cycle; busy only rises if the queue cannot
//   cover every beat in flight, which the never-stalling back part prevents.
//   Register: csr_max_code_block_bits is written with csr_valid (csr_ready is always
//   high); the user writes only while no request is in flight, unchecked by the block; values below 25 act as 25.
//   Reset: synchronous; empties the pipeline and queue and restores the code
//   block size to 2048. The receiver cannot stall, so nothing is held back.
// ----------------------------------------------------------------------------
module transport_block_size_calc_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tbs_pkg::SS_W-1:0]       req_spatial_streams,
   input  logic [tbs_pkg::SC_W-1:0]       req_data_subcarriers,
   input  logic [tbs_pkg::BPS_W-1:0]      req_bits_per_symbol,
   input  logic [tbs_pkg::RATE_W-1:0]     req_rate_numerator,
   input  logic [tbs_pkg::RATE_W-1:0]     req_rate_denominator,
   output logic                           rsp_strobe,
   output logic [tbs_pkg::BITS_W-1:0]     rsp_coded_bits,
   output logic [tbs_pkg::BITS_W-1:0]     rsp_block_bits,
   output logic [tbs_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tbs_pkg::Z_W-1:0]        csr_max_code_block_bits
);

   logic [tbs_pkg::Z_W-1:0]     z_ff;
   logic [tbs_pkg::Z_W-1:0]     z_in;
   tbs_pkg::beat_type           push;
   tbs_pkg::beat_type           head;
   logic [tbs_pkg::QCNT_W-1:0]  queue_level;

   // code block size register
   assign csr_ready = 1'b1;
   assign z_in      = (csr_valid & csr_ready) ? csr_max_code_block_bits : z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         z_ff <= tbs_pkg::Z_RESET;
      end else begin
         z_ff <= z_in;
      end
   end

   // intake and classification
   tbs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .spatial_streams  (req_spatial_streams),
      .data_subcarriers (req_data_subcarriers),
      .bits_per_symbol  (req_bits_per_symbol),
      .rate_numerator   (req_rate_numerator),
      .rate_denominator (req_rate_denominator),
      .queue_level      (queue_level),
      .push             (push)
   );

   // decoupling queue
   tbs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (head),
      .level (queue_level)
   );

   // size calculation
   tbs_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .max_code_block_bits (z_ff),
      .rsp_strobe          (rsp_strobe),
      .rsp_coded_bits      (rsp_coded_bits),
      .rsp_block_bits      (rsp_block_bits),
      .rsp_status          (rsp_status)
   );

endmodule
